// ----- src/dslr_pkg.sv -----
// ----------------------------------------------------------------------------
// dslr_pkg
// Shared widths, constants and fixed-point helpers for the shielding block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dslr_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int KARMAN_W   = 17;
  localparam int FLOOR_W    = 16;
  localparam int SHIELD_W   = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DATA_W-1:0] ONE    = DATA_W'(1) << FRAC_W;
  localparam logic [DATA_W-1:0] RD_MAX = DATA_W'(10) << FRAC_W;
  localparam logic [DATA_W-1:0] U_BIG  = DATA_W'(4) << FRAC_W;

  // long division: 56-bit dividend, 40-bit divisor, one quotient bit a stage
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_STEPS = DIV_NUM_W;

  // square root of a 48-bit radicand, one root bit a stage
  localparam int SQRT_RAD_W = 48;
  localparam int SQRT_W     = 24;
  localparam int SQRT_REM_W = SQRT_W + 2;
  localparam int SQRT_STEPS = SQRT_W;

  // tanh unit: five arithmetic stages, the divider, one output stage
  localparam int TANH_PRE = 5;
  localparam int TANH_LAT = TANH_PRE + DIV_STEPS + 1;

  // front stages before the first divider, and join stages before the last
  localparam int FRONT_LAT = 3;
  localparam int SHAPE_LAT = 3;
  localparam int JOIN_LAT  = 3;
  localparam int ROOT_DLY  = SHAPE_LAT + TANH_LAT - SQRT_STEPS;
  localparam int CD_DLY    = DIV_STEPS + SHAPE_LAT + TANH_LAT;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_STEPS + SHAPE_LAT + TANH_LAT
                             + JOIN_LAT + DIV_STEPS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIELD = 2'd0,
    CFG_DES    = 2'd1,
    CFG_KARMAN = 2'd2,
    CFG_FLOOR  = 2'd3
  } cfg_idx_t;

  // Q16.16 product, truncated, saturating to all ones
  function automatic logic [DATA_W-1:0] mulq(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
    logic [2*DATA_W-1:0] prod;
    logic [2*DATA_W-1:0] sh;
    prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    sh   = prod >> FRAC_W;
    return (|sh[2*DATA_W-1:DATA_W]) ? '1 : sh[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/dslr_if.sv -----
// ----------------------------------------------------------------------------
// dslr channel interfaces
// Valid/ready request channels for cell inputs and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dslr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] eff_viscosity;
  logic [31:0] grad_magnitude;
  logic [31:0] wall_distance;
  logic [31:0] strain_rate;
  logic [31:0] model_variable;
  logic [31:0] filter_width;
  modport source (output valid, eff_viscosity, grad_magnitude, wall_distance,
                  strain_rate, model_variable, filter_width, input ready);
  modport sink (input valid, eff_viscosity, grad_magnitude, wall_distance,
                strain_rate, model_variable, filter_width, output ready);
endinterface

interface dslr_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] shield_value;
  logic [31:0] length_ratio;
  modport source (output valid, shield_value, length_ratio, input ready);
  modport sink (input valid, shield_value, length_ratio, output ready);
endinterface
`default_nettype wire

// ----- src/dslr_div.sv -----
// ----------------------------------------------------------------------------
// dslr_div
// Pipelined restoring divider, one quotient bit per stage, saturating result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dslr_div (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [dslr_pkg::DIV_NUM_W-1:0]    num,
  input  wire logic [dslr_pkg::DIV_DEN_W-1:0]    den,
  output logic      [dslr_pkg::DATA_W-1:0]       quo
);
  import dslr_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [DIV_STEPS];
  logic [DIV_NUM_W-1:0] num_q [DIV_STEPS];
  logic [DIV_NUM_W-1:0] quo_q [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_q [DIV_STEPS];

  logic [DIV_DEN_W-1:0] rem_in [DIV_STEPS];
  logic [DIV_NUM_W-1:0] num_in [DIV_STEPS];
  logic [DIV_NUM_W-1:0] quo_in [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_in [DIV_STEPS];
  logic [DIV_DEN_W:0]   trial  [DIV_STEPS];
  logic [DIV_DEN_W:0]   diff   [DIV_STEPS];
  logic                 ge     [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        rem_in[k] = '0;
        num_in[k] = num;
        quo_in[k] = '0;
        den_in[k] = den;
      end else begin
        rem_in[k] = rem_q[k-1];
        num_in[k] = num_q[k-1];
        quo_in[k] = quo_q[k-1];
        den_in[k] = den_q[k-1];
      end
      trial[k] = {rem_in[k], num_in[k][DIV_NUM_W-1]};
      diff[k]  = trial[k] - {1'b0, den_in[k]};
      ge[k]    = trial[k] >= {1'b0, den_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k] <= ge[k] ? diff[k][DIV_DEN_W-1:0] : trial[k][DIV_DEN_W-1:0];
        num_q[k] <= num_in[k] << 1;
        quo_q[k] <= {quo_in[k][DIV_NUM_W-2:0], ge[k]};
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quo = (|quo_q[DIV_STEPS-1][DIV_NUM_W-1:DATA_W]) ? '1
             : quo_q[DIV_STEPS-1][DATA_W-1:0];

endmodule
`default_nettype wire

// ----- src/dslr_sqrt.sv -----
// ----------------------------------------------------------------------------
// dslr_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dslr_sqrt (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [dslr_pkg::SQRT_RAD_W-1:0]   rad,
  output logic      [dslr_pkg::SQRT_W-1:0]       root
);
  import dslr_pkg::*;

  logic [SQRT_REM_W-1:0] rem_q  [SQRT_STEPS];
  logic [SQRT_RAD_W-1:0] rad_q  [SQRT_STEPS];
  logic [SQRT_W-1:0]     root_q [SQRT_STEPS];

  logic [SQRT_REM_W-1:0] rem_in  [SQRT_STEPS];
  logic [SQRT_RAD_W-1:0] rad_in  [SQRT_STEPS];
  logic [SQRT_W-1:0]     root_in [SQRT_STEPS];
  logic [SQRT_REM_W+1:0] cur     [SQRT_STEPS];
  logic [SQRT_REM_W+1:0] tst     [SQRT_STEPS];
  logic [SQRT_REM_W+1:0] diff    [SQRT_STEPS];
  logic                  ge      [SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        rad_in[k]  = rad;
        root_in[k] = '0;
      end else begin
        rem_in[k]  = rem_q[k-1];
        rad_in[k]  = rad_q[k-1];
        root_in[k] = root_q[k-1];
      end
      cur[k]  = {rem_in[k], rad_in[k][SQRT_RAD_W-1 -: 2]};
      tst[k]  = {2'b00, root_in[k], 2'b01};
      diff[k] = cur[k] - tst[k];
      ge[k]   = cur[k] >= tst[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        rem_q[k]  <= ge[k] ? diff[k][SQRT_REM_W-1:0] : cur[k][SQRT_REM_W-1:0];
        rad_q[k]  <= rad_in[k] << 2;
        root_q[k] <= {root_in[k][SQRT_W-2:0], ge[k]};
      end
    end
  end

  assign root = root_q[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ----- src/dslr_tanh.sv -----
// ----------------------------------------------------------------------------
// dslr_tanh
// Shielding value 1 - tanh(u) from a 7th-order continued-fraction ratio.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dslr_tanh (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [dslr_pkg::DATA_W-1:0]    u,
  output logic      [dslr_pkg::SHIELD_W-1:0]  fd
);
  import dslr_pkg::*;

  localparam int U_W  = FRAC_W + 2;
  localparam int U2_W = U_W + 2;
  localparam int U4_W = U2_W + 4;
  localparam int U6_W = U4_W + 4;
  localparam int PQ_W = 38;

  logic [U_W-1:0]  t1_u, t2_u, t3_u, t4_u;
  logic            t1_big, t2_big, t3_big, t4_big, t5_big;
  logic [U2_W-1:0] t1_u2, t2_u2, t3_u2;
  logic [U4_W-1:0] t2_u4, t3_u4;
  logic [U6_W-1:0] t3_u6;
  logic [PQ_W-1:0] t4_p, t4_q, t5_q;
  logic [DIV_NUM_W-1:0] t5_n;
  logic [2*U2_W-1:0]    sq2;
  logic [U4_W+U2_W-1:0] pr6;
  logic [PQ_W-1:0]      p_next, q_next;
  logic                 big_dly [DIV_STEPS];
  logic [DATA_W-1:0]    t_quo;
  logic [DATA_W-1:0]    t_cap;

  // stage 2 forms u^4 from u^2, stage 3 forms u^6 from u^4 and u^2
  assign sq2 = (2*U2_W)'(t1_u2) * (2*U2_W)'(t1_u2);
  assign pr6 = (U4_W+U2_W)'(t2_u4) * (U4_W+U2_W)'(t2_u2);

  assign p_next = (PQ_W'(135135) << FRAC_W) + PQ_W'(17325) * PQ_W'(t3_u2)
                + PQ_W'(378) * PQ_W'(t3_u4) + PQ_W'(t3_u6);
  assign q_next = (PQ_W'(135135) << FRAC_W) + PQ_W'(62370) * PQ_W'(t3_u2)
                + PQ_W'(3150) * PQ_W'(t3_u4) + PQ_W'(28) * PQ_W'(t3_u6);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_u   <= u[U_W-1:0];
      t1_big <= u >= U_BIG;
      t1_u2  <= U2_W'((2*U_W)'(u[U_W-1:0]) * (2*U_W)'(u[U_W-1:0]) >> FRAC_W);
      t2_u   <= t1_u;
      t2_big <= t1_big;
      t2_u2  <= t1_u2;
      t2_u4  <= U4_W'(sq2 >> FRAC_W);
      t3_u   <= t2_u;
      t3_big <= t2_big;
      t3_u2  <= t2_u2;
      t3_u4  <= t2_u4;
      t3_u6  <= U6_W'(pr6 >> FRAC_W);
      t4_u   <= t3_u;
      t4_big <= t3_big;
      t4_p   <= p_next;
      t4_q   <= q_next;
      t5_big <= t4_big;
      t5_n   <= DIV_NUM_W'(t4_u) * DIV_NUM_W'(t4_p);
      t5_q   <= t4_q;
      big_dly[0] <= t5_big;
      for (int k = 1; k < DIV_STEPS; k++) big_dly[k] <= big_dly[k-1];
      fd <= t_cap[SHIELD_W-1:0];
    end
  end

  dslr_div u_div (
    .clk (clk),
    .en  (en),
    .num (t5_n),
    .den (DIV_DEN_W'(t5_q)),
    .quo (t_quo)
  );

  // fd = one minus tanh, tanh capped at one; saturated argument gives zero
  assign t_cap = big_dly[DIV_STEPS-1] ? '0
               : ONE - ((t_quo > ONE) ? ONE : t_quo);

endmodule
`default_nettype wire

// ----- src/ddes_shielding_length_ratio_core.sv -----
// ----------------------------------------------------------------------------
// ddes_shielding_length_ratio_core
// Per-cell DDES shielding value and RANS/DDES length ratio, fully pipelined.
// ----------------------------------------------------------------------------
// One cell request enters per clock and one result leaves per clock while
// the output is not stalled. The pipe is built around a chain of three
// 56-stage long dividers (rd, tanh ratio, final length ratio) with the
// square-root and multiplier stages around them. The whole pipe moves on
// one enable: it advances whenever the output register is empty or being
// taken, so a stalled result holds the pipe and nothing is lost or
// repeated. Configuration must be written through cfg_we/cfg_index/cfg_data
// while no request is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module ddes_shielding_length_ratio_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [dslr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dslr_pkg::DATA_W-1:0]      cfg_data,
  dslr_in_if.sink                               in_ch,
  dslr_out_if.source                            out_ch
);
  import dslr_pkg::*;

  // configuration
  logic [DATA_W-1:0]   shield_coeff;
  logic [DATA_W-1:0]   des_coeff;
  logic [KARMAN_W-1:0] karman_const;
  logic [FLOOR_W-1:0]  tiny_floor;
  logic [DATA_W-1:0]   floor_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      shield_coeff <= DATA_W'(524288);
      des_coeff    <= DATA_W'(42598);
      karman_const <= KARMAN_W'(26870);
      tiny_floor   <= FLOOR_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHIELD: shield_coeff <= cfg_data;
        CFG_DES:    des_coeff    <= cfg_data;
        CFG_KARMAN: karman_const <= cfg_data[KARMAN_W-1:0];
        CFG_FLOOR:  tiny_floor   <= cfg_data[FLOOR_W-1:0];
        default:    ;
      endcase
    end
  end

  assign floor_w = DATA_W'(tiny_floor);

  // pipe enable and valid chain
  logic                 adv;
  logic [TOTAL_LAT-1:0] vpipe;

  assign adv          = !vpipe[TOTAL_LAT-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vpipe[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (adv) vpipe <= {vpipe[TOTAL_LAT-2:0], in_ch.valid};
  end

  // front: clamp gradient, kappa*y, Cdes*delta, (kappa*y)^2, gradient product
  logic [DATA_W-1:0] s1_nu, s1_g, s1_ky, s1_r, s1_s, s1_cd;
  logic [DATA_W-1:0] s2_nu, s2_g, s2_kk, s2_r, s2_s, s2_cd;
  logic [DATA_W-1:0] s3_nu, s3_den, s3_r, s3_s, s3_cd;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_nu  <= in_ch.eff_viscosity;
      s1_g   <= (in_ch.grad_magnitude < floor_w) ? floor_w : in_ch.grad_magnitude;
      s1_ky  <= mulq(DATA_W'(karman_const), in_ch.wall_distance);
      s1_r   <= in_ch.model_variable;
      s1_s   <= in_ch.strain_rate;
      s1_cd  <= mulq(des_coeff, in_ch.filter_width);
      s2_nu  <= s1_nu;
      s2_g   <= s1_g;
      s2_kk  <= mulq(s1_ky, s1_ky);
      s2_r   <= s1_r;
      s2_s   <= s1_s;
      s2_cd  <= s1_cd;
      s3_nu  <= s2_nu;
      s3_den <= mulq(s2_g, s2_kk);
      s3_r   <= s2_r;
      s3_s   <= s2_s;
      s3_cd  <= s2_cd;
    end
  end

  // rd quotient and R/S quotient run side by side
  logic [DATA_W-1:0] quo_rd, quo_rs;

  dslr_div u_div_rd (
    .clk (clk),
    .en  (adv),
    .num ({{(DIV_NUM_W-DATA_W-FRAC_W){1'b0}}, s3_nu, {FRAC_W{1'b0}}}),
    .den (DIV_DEN_W'(s3_den)),
    .quo (quo_rd)
  );

  dslr_div u_div_rs (
    .clk (clk),
    .en  (adv),
    .num ({{(DIV_NUM_W-DATA_W-FRAC_W){1'b0}}, s3_r, {FRAC_W{1'b0}}}),
    .den (DIV_DEN_W'(s3_s)),
    .quo (quo_rs)
  );

  // u = (Cd1*rd)^3, one multiply per stage
  logic [DATA_W-1:0] e1_x, e2_x, e2_x2, e3_u;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_x  <= mulq(shield_coeff, (quo_rd > RD_MAX) ? RD_MAX : quo_rd);
      e2_x  <= e1_x;
      e2_x2 <= mulq(e1_x, e1_x);
      e3_u  <= mulq(e2_x2, e2_x);
    end
  end

  logic [SHIELD_W-1:0] fd_t;

  dslr_tanh u_tanh (
    .clk (clk),
    .en  (adv),
    .u   (e3_u),
    .fd  (fd_t)
  );

  // RANS length sqrt(R/S), delayed to meet fd
  logic [SQRT_W-1:0] root;
  logic [SQRT_W-1:0] root_dly [ROOT_DLY];
  logic [DATA_W-1:0] cd_dly   [CD_DLY];

  dslr_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  ({quo_rs, {FRAC_W{1'b0}}}),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      root_dly[0] <= root;
      for (int k = 1; k < ROOT_DLY; k++) root_dly[k] <= root_dly[k-1];
      cd_dly[0] <= s3_cd;
      for (int k = 1; k < CD_DLY; k++) cd_dly[k] <= cd_dly[k-1];
    end
  end

  // join: lrans, fd*max(0, lrans - cd), lDDES
  logic [DATA_W-1:0]   j1_lrans, j1_diff, j2_lrans, j2_m, j3_lrans, j3_ldd;
  logic [SHIELD_W-1:0] j1_fd, j2_fd, j3_fd;
  logic [DATA_W-1:0]   lrans_w, ldd_w;

  assign lrans_w = (DATA_W'(root_dly[ROOT_DLY-1]) < floor_w) ? floor_w
                 : DATA_W'(root_dly[ROOT_DLY-1]);
  assign ldd_w   = j2_lrans - j2_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      j1_lrans <= lrans_w;
      j1_diff  <= (lrans_w > cd_dly[CD_DLY-1]) ? lrans_w - cd_dly[CD_DLY-1] : '0;
      j1_fd    <= fd_t;
      j2_lrans <= j1_lrans;
      j2_m     <= mulq(DATA_W'(j1_fd), j1_diff);
      j2_fd    <= j1_fd;
      j3_lrans <= j2_lrans;
      j3_ldd   <= (ldd_w < floor_w) ? floor_w : ldd_w;
      j3_fd    <= j2_fd;
    end
  end

  // lrans / lDDES; its last stage is the output register
  logic [SHIELD_W-1:0] fd_dly [DIV_STEPS];

  dslr_div u_div_ratio (
    .clk (clk),
    .en  (adv),
    .num ({{(DIV_NUM_W-DATA_W-FRAC_W){1'b0}}, j3_lrans, {FRAC_W{1'b0}}}),
    .den (DIV_DEN_W'(j3_ldd)),
    .quo (out_ch.length_ratio)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      fd_dly[0] <= j3_fd;
      for (int k = 1; k < DIV_STEPS; k++) fd_dly[k] <= fd_dly[k-1];
    end
  end

  assign out_ch.shield_value = fd_dly[DIV_STEPS-1];

  // checks
  a_shield_range : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.shield_value <= SHIELD_W'(ONE))
    else $error("shield value above one");

  a_ratio_min : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.length_ratio >= ONE)
    else $error("length ratio below one");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vpipe))
    else $error("valid chain moved during stall");

  a_ldd_bound : assert property (@(posedge clk) disable iff (rst)
    vpipe[FRONT_LAT+DIV_STEPS+SHAPE_LAT+TANH_LAT+1] |-> j2_m <= j2_lrans)
    else $error("shielded correction exceeds lrans");

endmodule
`default_nettype wire

// ----- tb/sv/dslr_result_checker.sv -----
// ----------------------------------------------------------------------------
// dslr_result_checker
// Watches the cell request and result channels of the shielding core, works
// out the shielding value and length ratio of each accepted cell and
// compares every accepted result with the oldest outstanding one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dslr_result_checker
  import dslr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  dslr_in_if                        in_ch,
  dslr_out_if                       out_ch,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic [SHIELD_W-1:0] shield;
    logic [DATA_W-1:0]   ratio;
  } cell_result_t;

  localparam logic [63:0] DMASK = 64'hFFFF_FFFF;
  localparam logic [63:0] Q1    = 64'd1 << FRAC_W;

  logic [DATA_W-1:0]   cd1_coeff;
  logic [DATA_W-1:0]   cdes_coeff;
  logic [KARMAN_W-1:0] kappa;
  logic [FLOOR_W-1:0]  len_floor;
  cell_result_t        cells_in_flight[$];

  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> FRAC_W;
    return (p > DMASK) ? DMASK : p[63:0];
  endfunction

  function automatic logic [63:0] fx_div(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] q;
    if (b == 0) return DMASK;
    q = (128'(a) << FRAC_W) / 128'(b);
    return (q > DMASK) ? DMASK : q[63:0];
  endfunction

  function automatic logic [63:0] fx_sqrt(input logic [63:0] a);
    logic [63:0] rad;
    logic [63:0] r;
    logic [63:0] c;
    rad = a << FRAC_W;
    r   = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= rad) r = c;
    end
    return r;
  endfunction

  // continued-fraction tanh, one at and above 4.0
  function automatic logic [63:0] fx_tanh(input logic [63:0] u);
    logic [63:0] u2, u4, u6, num, den, t;
    if (u >= 4 * Q1) return Q1;
    u2  = (u * u) >> FRAC_W;
    u4  = (u2 * u2) >> FRAC_W;
    u6  = (u4 * u2) >> FRAC_W;
    num = 135135 * Q1 + 17325 * u2 + 378 * u4 + u6;
    den = 135135 * Q1 + 62370 * u2 + 3150 * u4 + 28 * u6;
    t   = 64'((128'(u) * 128'(num)) / 128'(den));
    return (t > Q1) ? Q1 : t;
  endfunction

  function automatic cell_result_t compute_shielding(
    input logic [63:0] nu, input logic [63:0] g, input logic [63:0] y,
    input logic [63:0] s, input logic [63:0] r, input logic [63:0] delta);
    logic [63:0] ky, den, rd, x, u, fd, lrans, cd, diff, ldd;
    cell_result_t res;
    if (g < len_floor) g = 64'(len_floor);
    ky  = fx_mul(64'(kappa), y);
    den = fx_mul(g, fx_mul(ky, ky));
    rd  = fx_div(nu, den);
    if (rd > 10 * Q1) rd = 10 * Q1;
    x   = fx_mul(64'(cd1_coeff), rd);
    u   = fx_mul(fx_mul(x, x), x);
    fd  = Q1 - fx_tanh(u);
    lrans = fx_sqrt(fx_div(r, s));
    if (lrans < len_floor) lrans = 64'(len_floor);
    cd   = fx_mul(64'(cdes_coeff), delta);
    diff = (lrans > cd) ? lrans - cd : 0;
    ldd  = lrans - fx_mul(fd, diff);
    if (ldd < len_floor) ldd = 64'(len_floor);
    res.shield = fd[SHIELD_W-1:0];
    res.ratio  = DATA_W'(fx_div(lrans, ldd));
    return res;
  endfunction

  assign pending = cells_in_flight.size();

  always @(posedge clk) begin
    cell_result_t want;
    int           bad;
    bad = 0;
    if (rst) begin
      cd1_coeff  <= 32'd524288;
      cdes_coeff <= 32'd42598;
      kappa      <= 17'd26870;
      len_floor  <= 16'd1;
      errors     <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SHIELD: cd1_coeff  <= cfg_data;
          CFG_DES:    cdes_coeff <= cfg_data;
          CFG_KARMAN: kappa      <= cfg_data[KARMAN_W-1:0];
          CFG_FLOOR:  len_floor  <= cfg_data[FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        cells_in_flight.push_back(compute_shielding(in_ch.eff_viscosity,
          in_ch.grad_magnitude, in_ch.wall_distance, in_ch.strain_rate,
          in_ch.model_variable, in_ch.filter_width));
      if (out_ch.valid && out_ch.ready) begin
        if (cells_in_flight.size() == 0) begin
          $display("%0t: unexpected result shield=%0d ratio=%0d", $time,
                   out_ch.shield_value, out_ch.length_ratio);
          bad = bad + 1;
        end else begin
          want = cells_in_flight.pop_front();
          if (out_ch.shield_value !== want.shield) begin
            $display("%0t: shield_value expected %0d actual %0d", $time,
                     want.shield, out_ch.shield_value);
            bad = bad + 1;
          end
          if (out_ch.length_ratio !== want.ratio) begin
            $display("%0t: length_ratio expected %0d actual %0d", $time,
                     want.ratio, out_ch.length_ratio);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/ddes_shielding_length_ratio_core_tb.sv -----
// ----------------------------------------------------------------------------
// ddes_shielding_length_ratio_core_tb
// Drives cell requests into the shielding core under several coefficient
// settings with bursty input and a stalling result side; the checker beside
// the core predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ddes_shielding_length_ratio_core_tb;
  import dslr_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int PHASE_CELLS  = 320;   // random requests per coefficient set
  localparam int HOLD_START   = 200;   // receiver cycle where the long stall begins
  localparam int HOLD_LEN     = 900;   // well past the pipe depth, so input backs up

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   burst_left = 0;

  dslr_in_if  in_ch();
  dslr_out_if out_ch();

  always #4 clk = ~clk;

  ddes_shielding_length_ratio_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  dslr_result_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending)
  );

  // run limit: well above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stall pattern redrawn at random among four modes, plus one long hold
  initial begin
    int rx_cycle;
    int mode;
    rx_cycle = 0;
    mode = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 128 == 0) mode = $urandom_range(0, 3);
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
        out_ch.ready <= 1'b0;
      else case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 9) < 7);
        2:       out_ch.ready <= (rx_cycle % 5 != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one request; gaps between bursts are inserted ahead of it
  task automatic send_cell(input logic [31:0] nu, input logic [31:0] g,
                           input logic [31:0] y, input logic [31:0] s,
                           input logic [31:0] r, input logic [31:0] delta);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.eff_viscosity  <= nu;
    in_ch.grad_magnitude <= g;
    in_ch.wall_distance  <= y;
    in_ch.strain_rate    <= s;
    in_ch.model_variable <= r;
    in_ch.filter_width   <= delta;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // field value: mostly around 1.0 so rd and fd land mid-range, some extremes
  function automatic logic [31:0] cell_field();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      4:       return $urandom_range(1, 255);
      default: return $urandom_range(32'h0000_0400, 32'h0008_0000);
    endcase
  endfunction

  // wait for the pipe to drain, then change coefficients
  task automatic load_coeffs(input logic [31:0] cd1, input logic [31:0] cdes,
                             input logic [16:0] kap, input logic [15:0] flr);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TOTAL_LAT + 10) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_SHIELD; cfg_data <= cd1;
    @(negedge clk);
    cfg_index <= CFG_DES;    cfg_data <= cdes;
    @(negedge clk);
    cfg_index <= CFG_KARMAN; cfg_data <= 32'(kap);
    @(negedge clk);
    cfg_index <= CFG_FLOOR;  cfg_data <= 32'(flr);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_cells(input int n);
    repeat (n) send_cell(cell_field(), cell_field(), cell_field(),
                         cell_field(), cell_field(), cell_field());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.eff_viscosity = '0;  in_ch.grad_magnitude = '0;
    in_ch.wall_distance = '0;  in_ch.strain_rate = '0;
    in_ch.model_variable = '0; in_ch.filter_width = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed cells under reset coefficients
    send_cell(0, 0, 0, 0, 0, 0);                    // zero denominators everywhere
    send_cell('1, '1, '1, '1, '1, '1);              // saturation all round
    send_cell(ONE, ONE, 0, ONE, ONE, ONE);          // y = 0: rd clamps to ten
    send_cell(ONE, ONE, ONE, 0, ONE, ONE);          // S = 0: lrans saturates
    send_cell(ONE, ONE, ONE, ONE, 0, ONE);          // R = 0: lrans on the floor
    send_cell(0, ONE, ONE, ONE, ONE, ONE);          // nu = 0: fd is one
    send_cell(ONE, 0, ONE, ONE, ONE, ONE);          // g below floor
    send_cell(32'd66, ONE, ONE * 4, ONE, ONE * 16, ONE);  // tanh argument small
    send_cell(32'd400, ONE, ONE * 4, ONE, ONE * 16, ONE); // tanh argument still small
    send_cell(32'd3000, ONE, ONE * 4, ONE, ONE * 16, ONE);// tanh argument still well below 4.0
    send_cell(32'd200, ONE, ONE * 4, ONE, ONE * 100, 32'd1000); // lrans above Cdes*delta
    send_cell(32'd200, ONE, ONE * 4, ONE, ONE, '1);      // lrans below Cdes*delta
    send_cell(ONE, ONE, ONE, 32'd1, '1, 32'd1);          // R/S saturates, tanh saturated: fd is zero, ratio is one
    send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000);
    send_cell(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
              32'h0000_0001, 32'h0000_0001);
    send_cell(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hAAAA_AAAA);
    send_cell(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hAAAA_AAAA, 32'h5555_5555);
    random_cells(PHASE_CELLS);

    // low extremes
    load_coeffs(32'd0, 32'd0, 17'd0, 16'd1);
    random_cells(PHASE_CELLS);
    // high extremes
    load_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd65536, 16'd65535);
    random_cells(PHASE_CELLS);
    // random coefficients
    load_coeffs($urandom, $urandom, 17'($urandom_range(0, 65536)),
                16'($urandom_range(1, 65535)));
    random_cells(PHASE_CELLS);
    // near nominal, slightly perturbed
    load_coeffs(32'd524288 + $urandom_range(0, 4096), 32'd42598 - $urandom_range(0, 2000),
                17'd26870 + 17'($urandom_range(0, 500)), 16'($urandom_range(1, 64)));
    random_cells(PHASE_CELLS);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TOTAL_LAT + 20) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
src/dslr_pkg.sv
src/dslr_if.sv
src/dslr_div.sv
src/dslr_sqrt.sv
src/dslr_tanh.sv
src/ddes_shielding_length_ratio_core.sv
tb/sv/dslr_result_checker.sv
tb/sv/ddes_shielding_length_ratio_core_tb.sv
